// ===== rtl/ctt_pkg.sv =====
// Shared constants, codes and controller/datapath types for the counted tag table.
package ctt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned TAG_W   = 31;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned STAT_W  = 2;

  // Payload word per slot: object, flags, skill, count (count in the lowest bits)
  localparam int unsigned PAY_W = 3 * WORD_W + COUNT_W;

  localparam int unsigned IN_BITS     = FUNC_W + TAG_W + 3 * WORD_W + COUNT_W + 1;
  localparam int unsigned OUT_BITS    = STAT_W + TAG_W + 3 * WORD_W + COUNT_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_MISSING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } ctt_state_e;

  typedef struct packed {
    logic start;    // latch request, restart the scan
    logic scan_rd;  // issue the next slot read
    logic finish;   // commit the update and load the result
  } ctt_cmd_t;

  typedef struct packed {
    logic hit;   // slot under compare satisfies the request
    logic last;  // slot under compare is the final one
  } ctt_sts_t;

endpackage

// ===== rtl/counted_tag_table.sv =====
// Counted tag table: per request, scan of the slots from the lowest index, one slot per cycle.
// A request ends its scan at the first matching slot; a miss or a full table scans all TABLE_DEPTH slots.
// Throughput: one request at a time; the next is taken the cycle after the result transaction.
// The scan rate is set by the single read port of the tag and payload memories.
// Reset: all slots free (valid bits cleared at once), tag counter zero, no clearing pass.
module counted_tag_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: func[1:0], tag[32:2], object_id[64:33], attack_flags[96:65],
  //        skill_id[128:97], hit_count[144:129], force_req[145], zero fill
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ctt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tdata: status[1:0], result_tag[32:2], found_object_id[64:33],
  //        found_attack_flags[96:65], found_skill_id[128:97],
  //        found_hit_count[144:129], zero fill
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ctt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import ctt_pkg::*;

  ctt_cmd_t cmd;
  ctt_sts_t sts;

  logic [FUNC_W-1:0]  in_func;
  logic [TAG_W-1:0]   in_tag;
  logic [WORD_W-1:0]  in_object, in_flags, in_skill;
  logic [COUNT_W-1:0] in_count;
  logic               in_force;

  logic [STAT_W-1:0]  out_status;
  logic [TAG_W-1:0]   out_tag;
  logic [WORD_W-1:0]  out_object, out_flags, out_skill;
  logic [COUNT_W-1:0] out_count;

  assign in_func   = s_axis_tdata[0 +: FUNC_W];
  assign in_tag    = s_axis_tdata[FUNC_W +: TAG_W];
  assign in_object = s_axis_tdata[FUNC_W + TAG_W +: WORD_W];
  assign in_flags  = s_axis_tdata[FUNC_W + TAG_W + WORD_W +: WORD_W];
  assign in_skill  = s_axis_tdata[FUNC_W + TAG_W + 2 * WORD_W +: WORD_W];
  assign in_count  = s_axis_tdata[FUNC_W + TAG_W + 3 * WORD_W +: COUNT_W];
  assign in_force  = s_axis_tdata[FUNC_W + TAG_W + 3 * WORD_W + COUNT_W];

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                         out_count, out_skill, out_flags, out_object, out_tag, out_status};

  ctt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ctt_dpath u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .func_i               (in_func),
    .tag_i                (in_tag),
    .object_id_i          (in_object),
    .attack_flags_i       (in_flags),
    .skill_id_i           (in_skill),
    .hit_count_i          (in_count),
    .force_req_i          (in_force),
    .status_o             (out_status),
    .result_tag_o         (out_tag),
    .found_object_id_o    (out_object),
    .found_attack_flags_o (out_flags),
    .found_skill_id_o     (out_skill),
    .found_hit_count_o    (out_count)
  );

endmodule

// ===== rtl/ctt_ctrl.sv =====
// Controller state machine: accept, scan sequencing and result handshake.
module ctt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ctt_pkg::ctt_sts_t sts_i,
  output ctt_pkg::ctt_cmd_t cmd_o
);
  import ctt_pkg::*;

  ctt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // stop at the first matching slot or after the final one
        if (sts_i.hit || sts_i.last) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_RESP;
        end else begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ctt_dpath.sv =====
// Datapath: request registers, slot memories, valid bits, tag counter and result register.
module ctt_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctt_pkg::ctt_cmd_t             cmd_i,
  output ctt_pkg::ctt_sts_t             sts_o,
  input  logic [ctt_pkg::FUNC_W-1:0]    func_i,
  input  logic [ctt_pkg::TAG_W-1:0]     tag_i,
  input  logic [ctt_pkg::WORD_W-1:0]    object_id_i,
  input  logic [ctt_pkg::WORD_W-1:0]    attack_flags_i,
  input  logic [ctt_pkg::WORD_W-1:0]    skill_id_i,
  input  logic [ctt_pkg::COUNT_W-1:0]   hit_count_i,
  input  logic                          force_req_i,
  output logic [ctt_pkg::STAT_W-1:0]    status_o,
  output logic [ctt_pkg::TAG_W-1:0]     result_tag_o,
  output logic [ctt_pkg::WORD_W-1:0]    found_object_id_o,
  output logic [ctt_pkg::WORD_W-1:0]    found_attack_flags_o,
  output logic [ctt_pkg::WORD_W-1:0]    found_skill_id_o,
  output logic [ctt_pkg::COUNT_W-1:0]   found_hit_count_o
);
  import ctt_pkg::*;

  // request
  logic [FUNC_W-1:0]  req_func_q;
  logic [TAG_W-1:0]   req_tag_q, req_tag_d;
  logic [PAY_W-1:0]   req_pay_q;
  logic               req_force_q;

  // tag counter
  logic [TAG_W-1:0]   ctr_q, ctr_d, ctr_inc, ctr_fresh;

  // slot storage
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [TAG_W-1:0]       tag_mem [TABLE_DEPTH];
  logic [PAY_W-1:0]       pay_mem [TABLE_DEPTH];
  logic [TAG_W-1:0]       tag_rd_q;
  logic [PAY_W-1:0]       pay_rd_q;

  // scan pipeline
  logic [IDX_W-1:0] rd_idx_q, cmp_idx_q;
  logic             cmp_vld_q;

  logic               hit_raw, hit, last;
  logic               tag_we, pay_we, free_slot;
  logic [COUNT_W-1:0] cur_cnt, new_cnt;
  logic [PAY_W-1:0]   pay_wdata;

  assign ctr_inc   = ctr_q + TAG_W'(1);
  assign ctr_fresh = (ctr_inc == '0) ? TAG_W'(1) : ctr_inc;

  always_comb begin
    ctr_d     = ctr_q;
    req_tag_d = tag_i;
    if (func_i == FUNC_ADD && tag_i == '0) begin
      ctr_d     = ctr_fresh;
      req_tag_d = ctr_fresh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else if (cmd_i.start) begin
      ctr_q <= ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_func_q  <= func_i;
      req_tag_q   <= req_tag_d;
      req_pay_q   <= {object_id_i, attack_flags_i, skill_id_i, hit_count_i};
      req_force_q <= force_req_i;
    end
  end

  // Scan: read slot rd_idx this cycle, compare it the next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.scan_rd) begin
        cmp_idx_q <= rd_idx_q;
        if (rd_idx_q != IDX_W'(TABLE_DEPTH - 1)) begin
          rd_idx_q <= rd_idx_q + IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    case (req_func_q) inside
      FUNC_ADD:                 hit_raw = !valid_q[cmp_idx_q];
      FUNC_LOOKUP, FUNC_REMOVE: hit_raw = valid_q[cmp_idx_q] && (tag_rd_q == req_tag_q);
      default:                  hit_raw = 1'b0;
    endcase
  end

  assign hit        = cmp_vld_q && hit_raw;
  assign last       = cmp_vld_q && (cmp_idx_q == IDX_W'(TABLE_DEPTH - 1));
  assign sts_o.hit  = hit;
  assign sts_o.last = last;

  // Remove: saturating decrement, free on zero or on force
  assign cur_cnt   = pay_rd_q[COUNT_W-1:0];
  assign new_cnt   = (cur_cnt == COUNT_MIN) ? cur_cnt : cur_cnt - COUNT_W'(1);
  assign free_slot = (new_cnt == '0) || req_force_q;

  assign tag_we    = cmd_i.finish && hit && (req_func_q == FUNC_ADD);
  assign pay_we    = cmd_i.finish && hit &&
                     ((req_func_q == FUNC_ADD) || (req_func_q == FUNC_REMOVE));
  assign pay_wdata = (req_func_q == FUNC_ADD) ? req_pay_q
                                              : {pay_rd_q[PAY_W-1:COUNT_W], new_cnt};

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[cmp_idx_q] <= req_tag_q;
    end
    tag_rd_q <= tag_mem[rd_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[cmp_idx_q] <= pay_wdata;
    end
    pay_rd_q <= pay_mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.finish) begin
      if (req_func_q == FUNC_ADD) begin
        if (hit) begin
          valid_q[cmp_idx_q] <= 1'b1;
        end else begin
          // table full: drop every entry
          valid_q <= '0;
        end
      end else if (req_func_q == FUNC_REMOVE && hit && free_slot) begin
        valid_q[cmp_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o             <= STS_MISSING;
      result_tag_o         <= '0;
      found_object_id_o    <= '0;
      found_attack_flags_o <= '0;
      found_skill_id_o     <= '0;
      found_hit_count_o    <= '0;
      case (req_func_q)
        FUNC_ADD: begin
          if (hit) begin
            status_o     <= STS_OK;
            result_tag_o <= req_tag_q;
          end else begin
            status_o <= STS_FULL;
          end
        end
        FUNC_LOOKUP: begin
          if (hit) begin
            status_o             <= STS_OK;
            result_tag_o         <= req_tag_q;
            found_object_id_o    <= pay_rd_q[PAY_W-1 -: WORD_W];
            found_attack_flags_o <= pay_rd_q[PAY_W-WORD_W-1 -: WORD_W];
            found_skill_id_o     <= pay_rd_q[COUNT_W +: WORD_W];
            found_hit_count_o    <= cur_cnt;
          end
        end
        FUNC_REMOVE: begin
          if (hit) begin
            status_o     <= STS_OK;
            result_tag_o <= req_tag_q;
          end
        end
        default: begin
          status_o <= STS_MISSING;
        end
      endcase
    end
  end

endmodule
